// ===== rtl/bsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrm_pkg
// Shared types, constants and the word mix function of the rotate-mix hash.
// ----------------------------------------------------------------------------
package bsrm_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = 8;
  localparam int IDX_W     = 3;
  localparam int PART_W    = 2;
  localparam int DIGEST_W  = 2 * WORD_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PART_W-1:0] part_t;

  // chain word initial values
  localparam word_t INIT_WORDS [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam part_t LAST_PART_IDX = 2'd3;

  // write request into the chain store
  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } wr_req_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  // a + S0(a) + b + S1'(b) + c, mod 2^32
  function automatic word_t mix_word(input word_t a, input word_t b, input word_t c);
    word_t s0;
    word_t s1;
    s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    s1 = rotr(b, 25) ^ rotr(b, 11) ^ b;
    mix_word = a + s0 + b + s1 + c;
  endfunction

endpackage

// ===== rtl/bsrm_in_if.sv =====
// ----------------------------------------------------------------------------
// bsrm_in_if
// Input channel: one message byte word per handshake.
// ----------------------------------------------------------------------------
interface bsrm_in_if import bsrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_valid;
  logic              end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

// ===== rtl/bsrm_out_if.sv =====
// ----------------------------------------------------------------------------
// bsrm_out_if
// Result channel: one 64-bit digest part per handshake.
// ----------------------------------------------------------------------------
interface bsrm_out_if import bsrm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DIGEST_W-1:0] digest_part;
  part_t               part_index;
  logic                last_part;

  modport source (output valid, digest_part, part_index, last_part, input ready);
  modport sink   (input valid, digest_part, part_index, last_part, output ready);
endinterface

// ===== rtl/bsrm_chain_mem.sv =====
// ----------------------------------------------------------------------------
// bsrm_chain_mem
// Chain word store: one write port, two registered read ports. Per-entry
// valid bits; an entry not written since the last clear reads as its
// initial constant.
// ----------------------------------------------------------------------------
module bsrm_chain_mem import bsrm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    clr,
  input  wr_req_t wr,
  input  idx_t    rd_a_addr,
  output word_t   rd_a_data,
  input  idx_t    rd_b_addr,
  output word_t   rd_b_data
);

  word_t                mem_r [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r;
  word_t                rd_a_data_r;
  word_t                rd_b_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data_r <= vld_r[rd_a_addr] ? mem_r[rd_a_addr] : INIT_WORDS[rd_a_addr];
    rd_b_data_r <= vld_r[rd_b_addr] ? mem_r[rd_b_addr] : INIT_WORDS[rd_b_addr];
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

// ===== rtl/byte_serial_rotate_mix_hash.sv =====
// ----------------------------------------------------------------------------
// byte_serial_rotate_mix_hash
// Streaming 256-bit rotate-mix hash over a byte message, one chain word
// mixed per cycle out of a small chain word store.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                     | accepted when
//  ---------+-----+---------------------------------------------+--------------------
//  in_ch    | in  | data_byte[7:0], byte_valid, end_of_message  | valid && ready
//  out_ch   | out | digest_part[63:0], part_index[1:0], last_part| valid && ready
//
//  - A word with a byte is mixed one chain word update per cycle
//    through the single mix unit, fed by a prefetch from the store's registered read port.
//    The next word is taken on the last mix cycle of a non-final byte, so bytes stream back to back.
//  - A final word starts the digest: four parts, each a read of two chain
//    words, then a load of the output register.
//  - Reset (rst_n low, synchronous) returns the chain to the initial constants
//    at once through per-entry valid bits; no clearing pass.
//  - A stalled output holds the digest sequencer; input is held off until
//    all four parts have been issued.
//
module byte_serial_rotate_mix_hash import bsrm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bsrm_in_if.sink      in_ch,
  bsrm_out_if.source   out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_MIX, ST_EMIT} state_t;

  state_t              state_r;
  idx_t                step_r;       // chain word being mixed
  part_t               part_k_r;     // next digest part to read
  part_t               pend_k_r;     // part whose read data lands this cycle
  logic                rd_pend_r;
  logic                eom_r;
  word_t               byte_ext_r;   // sign-extended byte
  word_t               w0_r;         // chain word 0 lives in a register
  word_t               a_r;          // previous b, i.e. word i before update
  logic                out_valid_r;
  logic [DIGEST_W-1:0] out_digest_r;
  part_t               out_index_r;
  logic                out_last_r;

  logic    in_ready;
  logic    in_acc;
  logic    emit_issue;
  logic    mem_clr;
  word_t   mix_a;
  word_t   mix_b;
  word_t   mix_res;
  wr_req_t wr_req;
  idx_t    rd_a_addr;
  idx_t    rd_b_addr;
  word_t   rd_a_data;
  word_t   rd_b_data;

  bsrm_chain_mem u_chain_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (mem_clr),
    .wr        (wr_req),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // Take a word when idle, or on the last mix step of a non-final byte.
  assign in_ready = (state_r == ST_IDLE) ||
                    ((state_r == ST_MIX) && (step_r == idx_t'(NUM_WORDS - 1)) && !eom_r);
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Word 0 uses the old register value; word 7 sees the updated word 0.
  assign mix_a   = (step_r == '0) ? w0_r : a_r;
  assign mix_b   = (step_r == idx_t'(NUM_WORDS - 1)) ? w0_r : rd_b_data;
  assign mix_res = mix_word(mix_a, mix_b, byte_ext_r);

  assign wr_req.en   = (state_r == ST_MIX) && (step_r != '0);
  assign wr_req.addr = step_r;
  assign wr_req.data = mix_res;

  // Issue a part read only when the output register is free by load time.
  assign emit_issue = (state_r == ST_EMIT) && !rd_pend_r && (!out_valid_r || out_ch.ready);
  assign mem_clr    = emit_issue && (part_k_r == LAST_PART_IDX);

  // Port b prefetches word i+2 while word i mixes; in idle and on the last
  // step it wraps to word 1, the first b of the next byte.
  assign rd_a_addr = {part_k_r, 1'b0};
  always_comb begin
    case (state_r)
      ST_MIX:  rd_b_addr = step_r + idx_t'(2);
      ST_EMIT: rd_b_addr = {part_k_r, 1'b1};
      default: rd_b_addr = idx_t'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      part_k_r    <= '0;
      pend_k_r    <= '0;
      rd_pend_r   <= 1'b0;
      eom_r       <= 1'b0;
      w0_r        <= INIT_WORDS[0];
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_MIX: begin
          if (step_r == '0) begin
            w0_r <= mix_res;
          end
          a_r    <= mix_b;
          step_r <= step_r + idx_t'(1);
          if (step_r == idx_t'(NUM_WORDS - 1)) begin
            if (eom_r) begin
              state_r  <= ST_EMIT;
              part_k_r <= '0;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (emit_issue) begin
            part_k_r <= part_k_r + part_t'(1);
            if (part_k_r == LAST_PART_IDX) begin
              state_r <= ST_IDLE;
              w0_r    <= INIT_WORDS[0];   // chain back to initial value
            end
          end
        end
        default: begin
        end
      endcase

      if (in_acc) begin
        byte_ext_r <= {{(WORD_W - BYTE_W){in_ch.data_byte[BYTE_W-1]}}, in_ch.data_byte};
        eom_r      <= in_ch.end_of_message;
        if (in_ch.byte_valid) begin
          state_r <= ST_MIX;
          step_r  <= '0;
        end else if (in_ch.end_of_message) begin
          state_r  <= ST_EMIT;
          part_k_r <= '0;
        end else begin
          state_r <= ST_IDLE;
        end
      end

      rd_pend_r <= emit_issue;
      if (emit_issue) begin
        pend_k_r <= part_k_r;
      end

      if (rd_pend_r) begin
        out_valid_r  <= 1'b1;
        out_digest_r <= {((pend_k_r == '0) ? w0_r : rd_a_data), rd_b_data};
        out_index_r  <= pend_k_r;
        out_last_r   <= (pend_k_r == LAST_PART_IDX);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_part = out_digest_r;
  assign out_ch.part_index  = out_index_r;
  assign out_ch.last_part   = out_last_r;

  // output register must be free when part read data lands
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("digest part loaded over a pending output word");

  // a byte word always starts the mix at word 0
  a_mix_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.byte_valid) |=> (state_r == ST_MIX) && (step_r == '0))
    else $error("byte accepted without starting the mix at word 0");

  // issuing the last part returns the chain to its initial state
  a_chain_reset: assert property (@(posedge clk) disable iff (!rst_n)
    mem_clr |=> (w0_r == INIT_WORDS[0]) && (state_r == ST_IDLE))
    else $error("chain not restored after final digest part");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_serial_rotate_mix_hash. Messages go in one
// word per handshake. A local chain model predicts the four digest parts of
// each message. A checker compares every accepted part, field by field,
// against the oldest pending prediction. The sender idles in random bursts
// and the receiver stalls on a mode pattern of its own.
// ----------------------------------------------------------------------------
module testbench import bsrm_pkg::*; ();

  localparam int ITEMS_RANDOM   = 145;   // plus the directed words, about 170 in all
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES  = 16;    // settle margin after the last pending part is checked

  // chain start values
  localparam word_t CHAIN_SEED [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [DIGEST_W-1:0] digest;
    part_t               index;
    logic                last;
  } digest_part_t;

  // receiver behavior: always ready, coin toss per cycle, or long stall runs
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BLOCK} rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bsrm_in_if  in_ch ();
  bsrm_out_if out_ch ();

  byte_serial_rotate_mix_hash dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state and pending digest parts
  word_t        chain_model [NUM_WORDS];
  digest_part_t digest_parts_due [$];

  int       errors       = 0;
  int       idle_cycles  = 0;
  int       burst_left   = 0;
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       stall_left   = 0;

  // --------------------------------------------------------------------------
  // Chain model
  // --------------------------------------------------------------------------
  function automatic word_t rot_right(input word_t x, input int unsigned n);
    logic [2*WORD_W-1:0] twice;
    twice = {x, x} >> n;
    return twice[WORD_W-1:0];
  endfunction

  // a + S0(a) + b + S1'(b) + c; note S1' xors b itself, not a third rotation
  function automatic word_t mix_chain_word(input word_t a, input word_t b, input word_t c);
    word_t sig_a;
    word_t sig_b;
    sig_a = rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22);
    sig_b = rot_right(b, 25) ^ rot_right(b, 11) ^ b;
    return a + sig_a + b + sig_b + c;
  endfunction

  // One accepted word: absorb the byte if present, then queue the digest
  // and restart the chain when the message ends.
  task automatic predict_digest(input logic [BYTE_W-1:0] data, input logic has_byte,
                                input logic msg_end);
    word_t        ext;
    digest_part_t part;
    if (has_byte) begin
      ext = {{(WORD_W-BYTE_W){data[BYTE_W-1]}}, data};  // signed char
      // in place, so word 7 picks up the fresh word 0
      for (int i = 0; i < NUM_WORDS; i++)
        chain_model[i] = mix_chain_word(chain_model[i], chain_model[(i+1) % NUM_WORDS], ext);
    end
    if (msg_end) begin
      for (int k = 0; k < NUM_WORDS/2; k++) begin
        part.digest = {chain_model[2*k], chain_model[2*k+1]};
        part.index  = part_t'(k);
        part.last   = (k == NUM_WORDS/2 - 1);
        digest_parts_due = {digest_parts_due, part};
      end
      chain_model = CHAIN_SEED;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitors. Everything samples at the rising edge; the DUT and the drivers
  // both update through nonblocking assignments, so pre-edge values are seen.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_digest(in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message);
  end

  always @(posedge clk) begin : check_result
    digest_part_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_parts_due.size() == 0) begin
        $display("%0t: unexpected digest part, expected none, actual %h index %0d last %0b",
                 $time, out_ch.digest_part, out_ch.part_index, out_ch.last_part);
        errors++;
      end else begin
        due = digest_parts_due.pop_front();
        if (out_ch.digest_part !== due.digest) begin
          $display("%0t: digest_part mismatch, expected %h, actual %h",
                   $time, due.digest, out_ch.digest_part);
          errors++;
        end
        if (out_ch.part_index !== due.index) begin
          $display("%0t: part_index mismatch, expected %0d, actual %0d",
                   $time, due.index, out_ch.part_index);
          errors++;
        end
        if (out_ch.last_part !== due.last) begin
          $display("%0t: last_part mismatch, expected %0b, actual %0b",
                   $time, due.last, out_ch.last_part);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern: pick a mode for a random stretch, then switch.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_ch.ready <= 1'b1;
      end
      RX_COIN: begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 20);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog: a correct run never goes this long without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver. Called at a rising edge; returns at the edge the word is taken.
  // Bursts of back-to-back words, random gaps between them. valid gets only
  // one assignment per time step.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [BYTE_W-1:0] data, input logic has_byte,
                           input logic msg_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data;
    in_ch.byte_valid     <= has_byte;
    in_ch.end_of_message <= msg_end;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, let the prediction for the last word land, then wait for
  // every pending part plus the block's own latency.
  task automatic wait_digest_drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (digest_parts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 7) != 0)
      return BYTE_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h7f;
      default: return 8'h80;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // empty message gives the start constants; twice in a row
  task automatic test_empty_message();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b1);
    wait_digest_drain();
  endtask

  // one byte plus the end mark, at the sign-extension edges
  task automatic test_single_byte_extremes();
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h7f, 1'b1, 1'b1);
    send_word(8'h80, 1'b1, 1'b1);
    wait_digest_drain();
  endtask

  // message closed by an end mark that carries no byte
  task automatic test_bare_end_after_bytes();
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'h3c, 1'b0, 1'b1);
    wait_digest_drain();
  endtask

  // words with neither a byte nor an end mark must leave the chain alone
  task automatic test_noise_words();
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h12, 1'b1, 1'b0);
    send_word(8'h80, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h81, 1'b1, 1'b1);
    wait_digest_drain();
  endtask

  // longer message, streamed back to back where the sender allows
  task automatic test_long_message();
    for (int j = 0; j < 8; j++)
      send_word(8'(8'h11 * j + 8'h0f), 1'b1, 1'b0);
    send_word(8'hc3, 1'b1, 1'b1);
    wait_digest_drain();
  endtask

  // Random messages: mostly well formed with random bytes, closed either by
  // a byte with the end mark or a bare end mark; some noise words mixed in.
  task automatic test_random_messages();
    int  counted;
    int  len;
    bit  closed;
    counted = 0;
    while (counted < ITEMS_RANDOM) begin
      len    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      closed = 1'b0;
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(BYTE_W'($urandom), 1'b0, 1'b0);
          counted++;
        end
        if (j == len - 1 && $urandom_range(0, 1) == 1) begin
          send_word(pick_byte(), 1'b1, 1'b1);
          closed = 1'b1;
        end else begin
          send_word(pick_byte(), 1'b1, 1'b0);
        end
        counted++;
      end
      if (!closed) begin
        send_word(BYTE_W'($urandom), 1'b0, 1'b1);
        counted++;
      end
    end
    wait_digest_drain();
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.byte_valid     = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b1;
    chain_model          = CHAIN_SEED;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_single_byte_extremes();
    test_bare_end_after_bytes();
    test_noise_words();
    test_long_message();
    test_random_messages();

    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// ===== byte_serial_rotate_mix_hash.f =====
rtl/bsrm_pkg.sv
rtl/bsrm_in_if.sv
rtl/bsrm_out_if.sv
rtl/bsrm_chain_mem.sv
rtl/byte_serial_rotate_mix_hash.sv
verif/testbench.sv
